/* rtl/core/hbd_pkg.sv */
// ============================================================================
// hbd_pkg
// Shared constants and types for the Huffman block decompressor.
// ============================================================================
package hbd_pkg;

    localparam int SYMBOL_LIMIT = 257;
    localparam int NODE_DEPTH   = 2 * SYMBOL_LIMIT - 1;
    localparam int STACK_DEPTH  = SYMBOL_LIMIT;
    localparam int NODE_W       = $clog2(NODE_DEPTH + 1);
    localparam int TOP_W        = $clog2(STACK_DEPTH + 1);
    localparam int SIDX_W       = $clog2(STACK_DEPTH);

    localparam logic [1:0] K_SYM    = 2'd0;
    localparam logic [1:0] K_BLOCK  = 2'd1;
    localparam logic [1:0] K_STREAM = 2'd2;
    localparam logic [1:0] K_ERROR  = 2'd3;

    localparam logic [7:0] BYTE_FF   = 8'hFF;
    localparam logic [7:0] BYTE_ZERO = 8'h00;

    typedef struct packed {
        logic              leaf;
        logic [NODE_W-1:0] lc;
        logic [NODE_W-1:0] rc;
        logic [7:0]        sym;
    } t_node;

    // one engine step toward the output stage
    typedef struct packed {
        logic       emit;
        logic       done;
        logic [7:0] sym;
        logic [1:0] kind;
    } t_step;

endpackage

/* rtl/core/hbd_if.sv */
// ============================================================================
// hbd_if
// Word channels of the Huffman block decompressor.
// ============================================================================
interface hbd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       end_of_stream;

    modport source (output valid, output data_byte, output end_of_stream, input ready);
    modport sink   (input valid, input data_byte, input end_of_stream, output ready);
endinterface

interface hbd_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] symbol;
    logic [1:0] kind;
    logic       last;

    modport source (output valid, output symbol, output kind, output last, input ready);
    modport sink   (input valid, input symbol, input kind, input last, output ready);
endinterface

/* rtl/core/hbd_engine.sv */
// ============================================================================
// hbd_engine
// Sequencer over the node memory and the build stack memory.
// ============================================================================
module hbd_engine
    import hbd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic [7:0] i_data_byte,
    input  logic       i_eos,
    output logic       o_in_ready,
    input  logic       i_stage_ready,
    output t_step      o_step
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_DISP  = 4'd1;
    localparam logic [3:0] S_TREE  = 4'd2;
    localparam logic [3:0] S_POPW  = 4'd3;
    localparam logic [3:0] S_TEND  = 4'd4;
    localparam logic [3:0] S_SEEK  = 4'd5;
    localparam logic [3:0] S_SEEKW = 4'd6;
    localparam logic [3:0] S_ROOT  = 4'd7;
    localparam logic [3:0] S_ROOTW = 4'd8;
    localparam logic [3:0] S_WALK  = 4'd9;
    localparam logic [3:0] S_WALKW = 4'd10;
    localparam logic [3:0] S_FIN   = 4'd11;

    localparam logic [2:0] PH_CNT_HI = 3'd0;
    localparam logic [2:0] PH_CNT_LO = 3'd1;
    localparam logic [2:0] PH_TREE   = 3'd2;
    localparam logic [2:0] PH_SYMS   = 3'd3;
    localparam logic [2:0] PH_DATA   = 3'd4;
    localparam logic [2:0] PH_HALT   = 3'd5;

    t_node             node_mem [NODE_DEPTH];
    logic [NODE_W-1:0] stk_mem  [STACK_DEPTH];

    logic [3:0]        r_st, n_st;
    logic [2:0]        r_phase, n_phase;
    logic [15:0]       r_total, n_total;
    logic [NODE_W-1:0] r_bits, n_bits;
    logic [TOP_W-1:0]  r_top, n_top;
    logic [NODE_W-1:0] r_tos, n_tos;
    logic [NODE_W-1:0] r_nf, n_nf;
    logic [NODE_W-1:0] r_cursor, n_cursor;
    logic [NODE_W-1:0] r_end_leaf, n_end_leaf;
    logic              r_end_valid, n_end_valid;
    logic [NODE_W-1:0] r_root, n_root;
    logic              r_esc, n_esc;
    logic [2:0]        r_k, n_k;
    logic [7:0]        r_byte, n_byte;
    logic              r_eos, n_eos;
    logic [NODE_W-1:0] r_child, n_child;
    t_node             r_cur, n_cur;
    t_node             r_root_ent, n_root_ent;

    logic              node_we, node_re;
    logic [NODE_W-1:0] node_waddr, node_raddr;
    t_node             node_wdata, node_rd;
    logic              stk_we, stk_re;
    logic [SIDX_W-1:0] stk_waddr, stk_raddr;
    logic [NODE_W-1:0] stk_wdata, stk_rd;

    logic [TOP_W-1:0]  top_m1, top_m2;
    logic [15:0]       total_lo;
    logic [NODE_W-1:0] walk_child;

    assign top_m1     = r_top - TOP_W'(1);
    assign top_m2     = r_top - TOP_W'(2);
    assign total_lo   = {r_total[15:8], r_byte};
    assign walk_child = r_byte[r_k] ? r_cur.rc : r_cur.lc;
    assign o_in_ready = (r_st == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (node_we) begin
            node_mem[node_waddr] <= node_wdata;
        end
        if (node_re) begin
            node_rd <= node_mem[node_raddr];
        end
        if (stk_we) begin
            stk_mem[stk_waddr] <= stk_wdata;
        end
        if (stk_re) begin
            stk_rd <= stk_mem[stk_raddr];
        end
    end

    always_comb begin
        n_st = r_st; n_phase = r_phase; n_total = r_total; n_bits = r_bits;
        n_top = r_top; n_tos = r_tos; n_nf = r_nf; n_cursor = r_cursor;
        n_end_leaf = r_end_leaf; n_end_valid = r_end_valid; n_root = r_root;
        n_esc = r_esc; n_k = r_k; n_byte = r_byte; n_eos = r_eos;
        n_child = r_child; n_cur = r_cur; n_root_ent = r_root_ent;
        node_we = 1'b0; node_waddr = r_nf; node_wdata = '0;
        node_re = 1'b0; node_raddr = r_cursor;
        stk_we = 1'b0; stk_waddr = top_m1[SIDX_W-1:0]; stk_wdata = r_tos;
        stk_re = 1'b0; stk_raddr = top_m2[SIDX_W-1:0];
        o_step = '0;

        case (r_st)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_byte = i_data_byte;
                    n_eos  = i_eos;
                    n_st   = S_DISP;
                end
            end
            S_DISP: begin
                if (i_stage_ready) begin
                    n_st = S_FIN;
                    if (r_phase == PH_HALT) begin
                        n_st = S_FIN;
                    end else if (r_eos) begin
                        o_step.emit = 1'b1;
                        if (r_phase == PH_CNT_HI) begin
                            o_step.kind = K_STREAM;
                        end else begin
                            o_step.kind = K_ERROR;
                            n_phase = PH_HALT;
                        end
                    end else begin
                        case (r_phase)
                            PH_CNT_HI: begin
                                n_total = {r_byte, 8'h00};
                                n_phase = PH_CNT_LO;
                            end
                            PH_CNT_LO: begin
                                n_total = total_lo;
                                if (total_lo == 16'd0 || total_lo > 16'(NODE_DEPTH)) begin
                                    o_step.emit = 1'b1;
                                    o_step.kind = K_ERROR;
                                    n_phase = PH_HALT;
                                end else begin
                                    n_top = '0; n_nf = '0; n_bits = '0;
                                    n_end_valid = 1'b0; n_esc = 1'b0;
                                    n_phase = PH_TREE;
                                end
                            end
                            PH_TREE: begin
                                n_k  = 3'd7;
                                n_st = S_TREE;
                            end
                            PH_SYMS: begin
                                node_waddr = r_cursor;
                                node_wdata.leaf = 1'b1;
                                if (r_esc) begin
                                    n_esc = 1'b0;
                                    node_we = 1'b1;
                                    if (r_byte == BYTE_ZERO) begin
                                        n_end_leaf  = r_cursor;
                                        n_end_valid = 1'b1;
                                    end else begin
                                        node_wdata.sym = BYTE_FF;
                                    end
                                end else if (r_byte == BYTE_FF) begin
                                    n_esc = 1'b1;
                                end else begin
                                    node_we = 1'b1;
                                    node_wdata.sym = r_byte;
                                end
                                if (node_we) begin
                                    n_cursor = r_cursor + NODE_W'(1);
                                    n_st = S_SEEK;
                                end
                            end
                            PH_DATA: begin
                                n_k  = 3'd7;
                                n_st = S_WALK;
                            end
                            default: begin
                                n_phase = PH_HALT;
                            end
                        endcase
                    end
                end
            end
            S_TREE: begin
                if (i_stage_ready) begin
                    if (16'(r_bits) >= r_total) begin
                        n_st = S_TEND;
                    end else if (!r_byte[r_k]) begin
                        if (r_top >= TOP_W'(STACK_DEPTH)) begin
                            o_step.emit = 1'b1;
                            o_step.kind = K_ERROR;
                            n_phase = PH_HALT;
                            n_st = S_FIN;
                        end else begin
                            node_we = 1'b1;
                            node_wdata.leaf = 1'b1;
                            stk_we = (r_top != '0);
                            n_tos  = r_nf;
                            n_top  = r_top + TOP_W'(1);
                            n_nf   = r_nf + NODE_W'(1);
                            n_bits = r_bits + NODE_W'(1);
                            n_st   = (r_k == 3'd0) ? S_TEND : S_TREE;
                            n_k    = r_k - 3'd1;
                        end
                    end else if (r_top < TOP_W'(2)) begin
                        o_step.emit = 1'b1;
                        o_step.kind = K_ERROR;
                        n_phase = PH_HALT;
                        n_st = S_FIN;
                    end else begin
                        stk_re = 1'b1;
                        n_st = S_POPW;
                    end
                end
            end
            S_POPW: begin
                node_we = 1'b1;
                node_wdata.lc = stk_rd;
                node_wdata.rc = r_tos;
                n_tos  = r_nf;
                n_top  = top_m1;
                n_nf   = r_nf + NODE_W'(1);
                n_bits = r_bits + NODE_W'(1);
                n_st   = (r_k == 3'd0) ? S_TEND : S_TREE;
                n_k    = r_k - 3'd1;
            end
            S_TEND: begin
                if (i_stage_ready) begin
                    n_st = S_FIN;
                    if (16'(r_bits) >= r_total) begin
                        if (r_top != TOP_W'(1)) begin
                            o_step.emit = 1'b1;
                            o_step.kind = K_ERROR;
                            n_phase = PH_HALT;
                        end else begin
                            n_root   = r_tos;
                            n_cursor = '0;
                            n_phase  = PH_SYMS;
                            n_st     = S_SEEK;
                        end
                    end
                end
            end
            S_SEEK: begin
                if (r_cursor >= r_nf) begin
                    n_phase = PH_DATA;
                    n_st = S_ROOT;
                end else begin
                    node_re = 1'b1;
                    n_st = S_SEEKW;
                end
            end
            S_SEEKW: begin
                if (node_rd.leaf) begin
                    n_st = S_FIN;
                end else begin
                    n_cursor = r_cursor + NODE_W'(1);
                    n_st = S_SEEK;
                end
            end
            S_ROOT: begin
                node_re    = 1'b1;
                node_raddr = r_root;
                n_st       = S_ROOTW;
            end
            S_ROOTW: begin
                n_root_ent = node_rd;
                n_cur      = node_rd;
                n_st       = S_FIN;
            end
            S_WALK: begin
                if (i_stage_ready) begin
                    if (r_cur.leaf) begin
                        o_step.emit = 1'b1;
                        o_step.kind = K_ERROR;
                        n_phase = PH_HALT;
                        n_st = S_FIN;
                    end else begin
                        node_re    = 1'b1;
                        node_raddr = walk_child;
                        n_child    = walk_child;
                        n_st       = S_WALKW;
                    end
                end
            end
            S_WALKW: begin
                if (i_stage_ready) begin
                    n_st = (r_k == 3'd0) ? S_FIN : S_WALK;
                    n_k  = r_k - 3'd1;
                    if (node_rd.leaf) begin
                        o_step.emit = 1'b1;
                        if (r_end_valid && r_child == r_end_leaf) begin
                            o_step.kind = K_BLOCK;
                            n_phase = PH_CNT_HI;
                            n_st = S_FIN;
                        end else begin
                            o_step.kind = K_SYM;
                            o_step.sym  = node_rd.sym;
                            n_cur = r_root_ent;
                        end
                    end else begin
                        n_cur = node_rd;
                    end
                end
            end
            S_FIN: begin
                if (i_stage_ready) begin
                    o_step.done = 1'b1;
                    n_st = S_IDLE;
                end
            end
            default: begin
                n_st = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE; r_phase <= PH_CNT_HI; r_total <= '0; r_bits <= '0;
            r_top <= '0; r_tos <= '0; r_nf <= '0; r_cursor <= '0;
            r_end_leaf <= '0; r_end_valid <= 1'b0; r_root <= '0; r_esc <= 1'b0;
            r_k <= '0;
        end else begin
            r_st <= n_st; r_phase <= n_phase; r_total <= n_total; r_bits <= n_bits;
            r_top <= n_top; r_tos <= n_tos; r_nf <= n_nf; r_cursor <= n_cursor;
            r_end_leaf <= n_end_leaf; r_end_valid <= n_end_valid; r_root <= n_root;
            r_esc <= n_esc; r_k <= n_k;
        end
    end

    always_ff @(posedge i_clk) begin
        r_byte <= n_byte; r_eos <= n_eos; r_child <= n_child;
        r_cur <= n_cur; r_root_ent <= n_root_ent;
    end

endmodule

/* rtl/core/hbd_out_stage.sv */
// ============================================================================
// hbd_out_stage
// Holds one result back until its last flag is known, then registers it.
// ============================================================================
module hbd_out_stage
    import hbd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_step      i_step,
    output logic       o_stage_ready,
    input  logic       i_ready,
    output logic       o_valid,
    output logic [7:0] o_symbol,
    output logic [1:0] o_kind,
    output logic       o_last
);

    logic       r_p_valid, r_o_valid;
    logic [7:0] r_p_sym;
    logic [1:0] r_p_kind;
    logic       out_free;

    assign out_free      = !r_o_valid || i_ready;
    assign o_stage_ready = !r_p_valid || out_free;
    assign o_valid       = r_o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_valid <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            if (r_o_valid && i_ready) begin
                r_o_valid <= 1'b0;
            end
            if (i_step.emit) begin
                r_p_valid <= 1'b1;
                if (r_p_valid) begin
                    r_o_valid <= 1'b1;
                end
            end else if (i_step.done && r_p_valid) begin
                r_p_valid <= 1'b0;
                r_o_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_step.emit) begin
            r_p_sym  <= i_step.sym;
            r_p_kind <= i_step.kind;
        end
        // move the held result out, flagged last only at the end of the word
        if (r_p_valid && (i_step.emit || i_step.done)) begin
            o_symbol <= r_p_sym;
            o_kind   <= r_p_kind;
            o_last   <= i_step.done;
        end
    end

endmodule

/* rtl/core/huffman_block_decompressor.sv */
// ============================================================================
// huffman_block_decompressor
// Decodes blocks of a post-order Huffman tree stream, one input word per step.
// ============================================================================
// Input channel i_in_ch carries one compressed byte (or a stream end mark)
// per word; output channel o_out_ch carries results: symbol, kind and a last
// flag on the final result caused by each input word.
// Each word is taken only while the engine is idle. A count word or the
// 0xFF of an escape passes accept, dispatch and finish. A symbol word also
// writes its leaf and seeks the next one, reading past each internal node;
// after the last symbol of a table the root is fetched. A tree word steps
// through its bits, a 0 bit in one step and a 1 bit in a stack read and a
// pop step, and when the tree closes in it, the end check and the seek to
// the first leaf follow. A data word takes one node memory read, then the
// child check, per bit.
// One result is held back until the next one or the end of the word is seen,
// so its last flag is known; it then moves to the output register.
// Reset clears all control state; the memories are not cleared and each
// node is written before it is read. After an error the block drops all
// further words until reset.
// A stalled receiver holds the engine at its next step once the output stage
// is full; no new word is taken until the engine is idle again.
// ============================================================================
module huffman_block_decompressor
    import hbd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    hbd_in_if.sink      i_in_ch,
    hbd_out_if.source   o_out_ch
);

    t_step step;
    logic  stage_ready;

    hbd_engine u_engine (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_ch.valid),
        .i_data_byte   (i_in_ch.data_byte),
        .i_eos         (i_in_ch.end_of_stream),
        .o_in_ready    (i_in_ch.ready),
        .i_stage_ready (stage_ready),
        .o_step        (step)
    );

    // hold each result until its last flag is settled
    hbd_out_stage u_out (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_step        (step),
        .o_stage_ready (stage_ready),
        .i_ready       (o_out_ch.ready),
        .o_valid       (o_out_ch.valid),
        .o_symbol      (o_out_ch.symbol),
        .o_kind        (o_out_ch.kind),
        .o_last        (o_out_ch.last)
    );

    // non-symbol results carry a zero symbol
    a_zero_sym: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_ch.valid && o_out_ch.kind != K_SYM) |-> (o_out_ch.symbol == 8'h00))
        else $error("non-symbol result with nonzero symbol");

    // block end, stream end and error always close a word
    a_final_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_ch.valid && o_out_ch.kind != K_SYM) |-> o_out_ch.last)
        else $error("terminal result without last flag");

    // one word at a time
    a_one_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_ch.valid && i_in_ch.ready) |=> !i_in_ch.ready)
        else $error("word taken while engine busy");

    // the engine never emits into a full stage
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (step.emit || step.done) |-> stage_ready)
        else $error("step issued to blocked output stage");

endmodule
